// File: rtl/obbc_pkg.sv
// ============================================================================
// Oriented box / circle contact: shared types
// Beat types for both channels, the sideband record that travels with each
// pair through the pipeline, stage counts and output saturation.
// ============================================================================
package obbc_pkg;

  localparam int SQRT_STAGES = 32;
  localparam int DIV_STAGES  = 17;

  typedef struct packed {
    logic               operation;
    logic signed [31:0] box_center_x;
    logic signed [31:0] box_center_y;
    logic signed [15:0] box_cos;
    logic signed [15:0] box_sin;
    logic        [30:0] box_half_width;
    logic        [30:0] box_half_height;
    logic signed [31:0] ball_center_x;
    logic signed [31:0] ball_center_y;
    logic        [30:0] ball_radius;
  } obbc_in_t;

  typedef struct packed {
    logic               colliding;
    logic signed [31:0] push_x;
    logic signed [31:0] push_y;
    logic signed [31:0] touch_x;
    logic signed [31:0] touch_y;
  } obbc_out_t;

  typedef struct packed {
    logic               op;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic        [30:0] r;
    logic        [30:0] hw0;
    logic        [30:0] hw1;
    logic signed [15:0] cs;
    logic signed [15:0] sn;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [16:0] nx0;
    logic signed [16:0] ny0;
    logic signed [16:0] nx1;
    logic signed [16:0] ny1;
    logic               best;
    logic signed [37:0] pen_b;
    logic               miss;
    logic signed [35:0] kx;
    logic signed [35:0] ky;
    logic               sx;
    logic               sy;
    logic               ez;
    logic signed [17:0] ax;
    logic signed [17:0] ay;
    logic               corner;
  } obbc_side_t;

  typedef struct packed {
    obbc_side_t  side;
    logic [30:0] mx;
    logic [30:0] my;
  } obbc_norm_t;

  function automatic logic [31:0] obbc_sat(input logic signed [47:0] v);
    logic [31:0] res;
    if (v > 48'sd2147483647) begin
      res = 32'h7fff_ffff;
    end else if (v < -48'sd2147483648) begin
      res = 32'h8000_0000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

endpackage

// File: rtl/obbc_isqrt.sv
// ============================================================================
// Pipelined integer square root
// One root bit per stage, floor root of a 63-bit value, sideband carried
// alongside; each stage advances when the next one can take its beat.
// ============================================================================
module obbc_isqrt import obbc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [62:0] in_sq_i,
  input  obbc_norm_t  in_norm_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] out_root_o,
  output obbc_norm_t  out_norm_o
);

  localparam int N = SQRT_STAGES;

  logic [N-1:0] v_q;
  logic [N-1:0] en;
  logic [62:0]  rem_q   [N];
  logic [31:0]  root_q  [N];
  obbc_norm_t   norm_q  [N];
  logic [62:0]  rem_src [N];
  logic [31:0]  root_src[N];
  logic [62:0]  rem_d   [N];
  logic [31:0]  root_d  [N];

  always_comb begin
    en[N-1] = !v_q[N-1] || !out_stall_i;
    for (int k = N - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_comb begin
    logic [63:0] trial;
    trial       = '0;
    rem_src[0]  = in_sq_i;
    root_src[0] = '0;
    for (int k = 1; k < N; k++) begin
      rem_src[k]  = rem_q[k-1];
      root_src[k] = root_q[k-1];
    end
    for (int k = 0; k < N; k++) begin
      trial = ({32'b0, root_src[k]} << (N - k)) | (64'd1 << (2 * (N - 1 - k)));
      if ({1'b0, rem_src[k]} >= trial) begin
        rem_d[k]  = rem_src[k] - trial[62:0];
        root_d[k] = root_src[k] | (32'd1 << (N - 1 - k));
      end else begin
        rem_d[k]  = rem_src[k];
        root_d[k] = root_src[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < N; k++) begin
        if (en[k]) begin
          v_q[k] <= (k == 0) ? in_valid_i : v_q[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < N; k++) begin
      if (en[k]) begin
        rem_q[k]  <= rem_d[k];
        root_q[k] <= root_d[k];
        norm_q[k] <= (k == 0) ? in_norm_i : norm_q[(k == 0) ? 0 : k - 1];
      end
    end
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = v_q[N-1];
  assign out_root_o  = root_q[N-1];
  assign out_norm_o  = norm_q[N-1];

endmodule

// File: rtl/obbc_div.sv
// ============================================================================
// Pipelined axis divider
// Two restoring dividers in lockstep, one quotient bit per stage, giving
// the 17-bit quotient (16 fraction bits) of each normalized component over the root length.
// ============================================================================
module obbc_div import obbc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  obbc_norm_t  in_norm_i,
  input  logic [31:0] in_len_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [16:0] out_ax_o,
  output logic [16:0] out_ay_o,
  output obbc_side_t  out_side_o
);

  localparam int N = DIV_STAGES;

  logic [N-1:0] v_q;
  logic [N-1:0] en;
  logic [46:0]  rx_q  [N];
  logic [46:0]  ry_q  [N];
  logic [16:0]  qx_q  [N];
  logic [16:0]  qy_q  [N];
  logic [31:0]  len_q [N];
  obbc_side_t   side_q[N];
  logic [46:0]  rx_src[N];
  logic [46:0]  ry_src[N];
  logic [16:0]  qx_src[N];
  logic [16:0]  qy_src[N];
  logic [31:0]  len_src[N];
  logic [46:0]  rx_d  [N];
  logic [46:0]  ry_d  [N];
  logic [16:0]  qx_d  [N];
  logic [16:0]  qy_d  [N];

  always_comb begin
    en[N-1] = !v_q[N-1] || !out_stall_i;
    for (int k = N - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_comb begin
    logic [47:0] dsh;
    dsh        = '0;
    rx_src[0]  = {in_norm_i.mx, 16'b0};
    ry_src[0]  = {in_norm_i.my, 16'b0};
    qx_src[0]  = '0;
    qy_src[0]  = '0;
    len_src[0] = in_len_i;
    for (int k = 1; k < N; k++) begin
      rx_src[k]  = rx_q[k-1];
      ry_src[k]  = ry_q[k-1];
      qx_src[k]  = qx_q[k-1];
      qy_src[k]  = qy_q[k-1];
      len_src[k] = len_q[k-1];
    end
    for (int k = 0; k < N; k++) begin
      dsh = {16'b0, len_src[k]} << (N - 1 - k);
      if ({1'b0, rx_src[k]} >= dsh) begin
        rx_d[k] = rx_src[k] - dsh[46:0];
        qx_d[k] = qx_src[k] | (17'd1 << (N - 1 - k));
      end else begin
        rx_d[k] = rx_src[k];
        qx_d[k] = qx_src[k];
      end
      if ({1'b0, ry_src[k]} >= dsh) begin
        ry_d[k] = ry_src[k] - dsh[46:0];
        qy_d[k] = qy_src[k] | (17'd1 << (N - 1 - k));
      end else begin
        ry_d[k] = ry_src[k];
        qy_d[k] = qy_src[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < N; k++) begin
        if (en[k]) begin
          v_q[k] <= (k == 0) ? in_valid_i : v_q[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < N; k++) begin
      if (en[k]) begin
        rx_q[k]   <= rx_d[k];
        ry_q[k]   <= ry_d[k];
        qx_q[k]   <= qx_d[k];
        qy_q[k]   <= qy_d[k];
        len_q[k]  <= len_src[k];
        side_q[k] <= (k == 0) ? in_norm_i.side : side_q[(k == 0) ? 0 : k - 1];
      end
    end
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = v_q[N-1];
  assign out_ax_o    = qx_q[N-1];
  assign out_ay_o    = qy_q[N-1];
  assign out_side_o  = side_q[N-1];

endmodule

// File: rtl/oriented_box_circle_contact_core.sv
// ============================================================================
// Oriented box / circle contact core
// Separating-axis test of one oriented box against one circle per beat:
// box axes, then the nearest-corner axis through a pipelined root and divide.
// ============================================================================
// Pipeline from accepted input beat to output beat: 10 front stages,
// 32 root stages, 17 divide stages, 9 back stages.
// Throughput: one pair per cycle; every stage advances whenever the stage
// after it is empty or moving, so bubbles close up under output stall.
// Reset clears all stage valid bits; the data path registers are not reset.
module oriented_box_circle_contact_core import obbc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  obbc_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output obbc_out_t out_data_o
);

  logic va_q, vb_q, vc_q, vd_q, ve_q, vf_q, vg_q, vh_q, vi_q, vj_q;
  logic vk_q, vl_q, vm_q, vn_q, vo_q, vp_q, vq_q, vr_q, vs_q;
  logic en_a, en_b, en_c, en_d, en_e, en_f, en_g, en_h, en_i, en_j;
  logic en_k, en_l, en_m, en_n, en_o, en_p, en_q, en_r, en_s;

  logic sq_valid, sq_stall, dv_valid, dv_stall, dv_stall_in;
  logic [31:0] sq_root;
  obbc_norm_t  sq_norm;
  logic [16:0] dv_ax, dv_ay;
  obbc_side_t  dv_side;

  obbc_side_t sa_d, sa_q, sb_q, sc_q, sd_d, sd_q, se_d, se_q, sf_d, sf_q, sg_q, sh_q, si_q;
  obbc_side_t sk_d, sk_q, sl_q, sm_q, sn_q, so_q, sp_d, sp_q, sq_q, sr_q;
  obbc_norm_t nj_q;
  obbc_out_t  out_d, out_q;

  logic signed [48:0] pu1_d, pu2_d, pv1_d, pv2_d, pu1_q, pu2_q, pv1_q, pv2_q;
  logic signed [49:0] su, sv;
  logic signed [35:0] du, dv;
  logic        [35:0] dab0_d, dab1_d, dab0_q, dab1_q;
  logic               f0_q, f1_q;
  logic signed [37:0] pen0_d, pen1_d, pen0_q, pen1_q;
  logic signed [16:0] nx0, ny0, nx1, ny1;
  logic signed [48:0] kx1_d, kx2_d, ky1_d, ky2_d, kx1_q, kx2_q, ky1_q, ky2_q;
  logic signed [49:0] kxs, kys;
  logic signed [36:0] ex_d, ey_d, ex_q, ey_q;
  logic        [36:0] mx_d, my_d, mm_d, mx_q, my_q, mm_q, mxg_q, myg_q;
  logic        [5:0]  msb;
  logic        [5:0]  amt6;
  logic               rsh_d, rsh_q;
  logic        [4:0]  amt_d, amt_q;
  logic        [36:0] shx, shy;
  logic        [30:0] mxn_d, myn_d, mxn_q, myn_q, mxi_q, myi_q;
  logic        [61:0] sqx_d, sqy_d, sqx_q, sqy_q;
  logic        [62:0] sqs_q;

  logic signed [17:0] axs, ays;
  logic signed [50:0] pdx_d, pdy_d, pdx_q, pdy_q;
  logic signed [34:0] qux_d, quy_d, qvx_d, qvy_d, qux_q, quy_q, qvx_q, qvy_q;
  logic signed [51:0] das;
  logic signed [35:0] dafl, qs0, qs1;
  logic        [35:0] da_d, da_q, dan_q, qa0, qa1;
  logic        [21:0] q0_d, q1_d, q0_q, q1_q;
  logic        [52:0] w0_d, w1_d, w0_q, w1_q;
  logic        [53:0] ws;
  logic signed [39:0] penc_d, penc_q;
  logic signed [39:0] mpen_d, mpen_q;
  logic signed [17:0] max_d, may_d, max_q, may_q;
  logic signed [16:0] nbx_d, nby_d, nbx_q, nby_q;
  logic signed [57:0] prx_d, pry_d, prx_q, pry_q;
  logic signed [48:0] rnx_d, rny_d, rnx_q, rny_q;
  logic signed [58:0] negx, negy;
  logic signed [44:0] pxw_d, pyw_d, pxw_q, pyw_q;
  logic signed [37:0] basex_d, basey_d, basex_q, basey_q;
  logic signed [34:0] rsx, rsy;
  logic signed [44:0] hx, hy;
  logic signed [47:0] tx48, ty48, px48, py48;

  // flow control
  assign en_s = !vs_q || !out_stall_i;
  assign en_r = !vr_q || en_s;
  assign en_q = !vq_q || en_r;
  assign en_p = !vp_q || en_q;
  assign en_o = !vo_q || en_p;
  assign en_n = !vn_q || en_o;
  assign en_m = !vm_q || en_n;
  assign en_l = !vl_q || en_m;
  assign en_k = !vk_q || en_l;
  assign dv_stall = !en_k;
  assign en_j = !vj_q || !sq_stall;
  assign en_i = !vi_q || en_j;
  assign en_h = !vh_q || en_i;
  assign en_g = !vg_q || en_h;
  assign en_f = !vf_q || en_g;
  assign en_e = !ve_q || en_f;
  assign en_d = !vd_q || en_e;
  assign en_c = !vc_q || en_d;
  assign en_b = !vb_q || en_c;
  assign en_a = !va_q || en_b;
  assign in_stall_o = !en_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0; vb_q <= 1'b0; vc_q <= 1'b0; vd_q <= 1'b0; ve_q <= 1'b0;
      vf_q <= 1'b0; vg_q <= 1'b0; vh_q <= 1'b0; vi_q <= 1'b0; vj_q <= 1'b0;
      vk_q <= 1'b0; vl_q <= 1'b0; vm_q <= 1'b0; vn_q <= 1'b0; vo_q <= 1'b0;
      vp_q <= 1'b0; vq_q <= 1'b0; vr_q <= 1'b0; vs_q <= 1'b0;
    end else begin
      if (en_a) va_q <= in_valid_i;
      if (en_b) vb_q <= va_q;
      if (en_c) vc_q <= vb_q;
      if (en_d) vd_q <= vc_q;
      if (en_e) ve_q <= vd_q;
      if (en_f) vf_q <= ve_q;
      if (en_g) vg_q <= vf_q;
      if (en_h) vh_q <= vg_q;
      if (en_i) vi_q <= vh_q;
      if (en_j) vj_q <= vi_q;
      if (en_k) vk_q <= dv_valid;
      if (en_l) vl_q <= vk_q;
      if (en_m) vm_q <= vl_q;
      if (en_n) vn_q <= vm_q;
      if (en_o) vo_q <= vn_q;
      if (en_p) vp_q <= vo_q;
      if (en_q) vq_q <= vp_q;
      if (en_r) vr_q <= vq_q;
      if (en_s) vs_q <= vr_q;
    end
  end

  // front stages: offset, box axis projections, corner, normalization
  always_comb begin
    sa_d     = '0;
    sa_d.op  = in_data_i.operation;
    sa_d.bx  = in_data_i.box_center_x;
    sa_d.by  = in_data_i.box_center_y;
    sa_d.cx  = in_data_i.ball_center_x;
    sa_d.cy  = in_data_i.ball_center_y;
    sa_d.r   = in_data_i.ball_radius;
    sa_d.hw0 = in_data_i.box_half_width;
    sa_d.hw1 = in_data_i.box_half_height;
    sa_d.cs  = in_data_i.box_cos;
    sa_d.sn  = in_data_i.box_sin;
    sa_d.dx  = {in_data_i.ball_center_x[31], in_data_i.ball_center_x}
             - {in_data_i.box_center_x[31], in_data_i.box_center_x};
    sa_d.dy  = {in_data_i.ball_center_y[31], in_data_i.ball_center_y}
             - {in_data_i.box_center_y[31], in_data_i.box_center_y};
  end

  assign pu1_d = $signed(sa_q.dx) * $signed(sa_q.cs);
  assign pu2_d = $signed(sa_q.dy) * $signed(sa_q.sn);
  assign pv1_d = $signed(sa_q.dx) * $signed(sa_q.sn);
  assign pv2_d = $signed(sa_q.dy) * $signed(sa_q.cs);

  always_comb begin
    su     = {pu1_q[48], pu1_q} + {pu2_q[48], pu2_q};
    sv     = {pv2_q[48], pv2_q} - {pv1_q[48], pv1_q};
    du     = su[49:14];
    dv     = sv[49:14];
    dab0_d = du[35] ? 36'd0 - du : du;
    dab1_d = dv[35] ? 36'd0 - dv : dv;
  end

  always_comb begin
    pen0_d = {7'b0, sc_q.hw0} + {7'b0, sc_q.r} - {2'b0, dab0_q};
    pen1_d = {7'b0, sc_q.hw1} + {7'b0, sc_q.r} - {2'b0, dab1_q};
    nx0    = f0_q ? 17'd0 - {sc_q.cs[15], sc_q.cs} : {sc_q.cs[15], sc_q.cs};
    ny0    = f0_q ? 17'd0 - {sc_q.sn[15], sc_q.sn} : {sc_q.sn[15], sc_q.sn};
    nx1    = f1_q ? {sc_q.sn[15], sc_q.sn} : 17'd0 - {sc_q.sn[15], sc_q.sn};
    ny1    = f1_q ? 17'd0 - {sc_q.cs[15], sc_q.cs} : {sc_q.cs[15], sc_q.cs};
    sd_d     = sc_q;
    sd_d.nx0 = nx0;
    sd_d.ny0 = ny0;
    sd_d.nx1 = nx1;
    sd_d.ny1 = ny1;
    kx1_d  = nx0 * $signed({1'b0, sc_q.hw0});
    kx2_d  = nx1 * $signed({1'b0, sc_q.hw1});
    ky1_d  = ny0 * $signed({1'b0, sc_q.hw0});
    ky2_d  = ny1 * $signed({1'b0, sc_q.hw1});
  end

  always_comb begin
    kxs        = {kx1_q[48], kx1_q} + {kx2_q[48], kx2_q};
    kys        = {ky1_q[48], ky1_q} + {ky2_q[48], ky2_q};
    se_d       = sd_q;
    se_d.kx    = kxs[49:14];
    se_d.ky    = kys[49:14];
    se_d.best  = pen1_q < pen0_q;
    se_d.pen_b = (pen1_q < pen0_q) ? pen1_q : pen0_q;
    se_d.miss  = pen0_q[37] | pen1_q[37];
    ex_d       = {{4{sd_q.dx[32]}}, sd_q.dx} - {kxs[49], kxs[49:14]};
    ey_d       = {{4{sd_q.dy[32]}}, sd_q.dy} - {kys[49], kys[49:14]};
  end

  always_comb begin
    mx_d    = ex_q[36] ? 37'd0 - ex_q : ex_q;
    my_d    = ey_q[36] ? 37'd0 - ey_q : ey_q;
    mm_d    = (mx_d > my_d) ? mx_d : my_d;
    sf_d    = se_q;
    sf_d.sx = ex_q[36];
    sf_d.sy = ey_q[36];
    sf_d.ez = (ex_q == '0) && (ey_q == '0);
  end

  always_comb begin
    msb = '0;
    for (int i = 0; i < 37; i++) begin
      if (mm_q[i]) msb = 6'(i);
    end
    rsh_d = msb > 6'd30;
    amt6  = rsh_d ? msb - 6'd30 : 6'd30 - msb;
    amt_d = amt6[4:0];
  end

  always_comb begin
    shx   = rsh_q ? (mxg_q >> amt_q) : (mxg_q << amt_q);
    shy   = rsh_q ? (myg_q >> amt_q) : (myg_q << amt_q);
    mxn_d = shx[30:0];
    myn_d = shy[30:0];
    sqx_d = mxn_q * mxn_q;
    sqy_d = myn_q * myn_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_a) sa_q <= sa_d;
    if (en_b) begin
      sb_q <= sa_q; pu1_q <= pu1_d; pu2_q <= pu2_d; pv1_q <= pv1_d; pv2_q <= pv2_d;
    end
    if (en_c) begin
      sc_q <= sb_q; dab0_q <= dab0_d; dab1_q <= dab1_d; f0_q <= du[35]; f1_q <= dv[35];
    end
    if (en_d) begin
      sd_q <= sd_d; pen0_q <= pen0_d; pen1_q <= pen1_d;
      kx1_q <= kx1_d; kx2_q <= kx2_d; ky1_q <= ky1_d; ky2_q <= ky2_d;
    end
    if (en_e) begin
      se_q <= se_d; ex_q <= ex_d; ey_q <= ey_d;
    end
    if (en_f) begin
      sf_q <= sf_d; mx_q <= mx_d; my_q <= my_d; mm_q <= mm_d;
    end
    if (en_g) begin
      sg_q <= sf_q; mxg_q <= mx_q; myg_q <= my_q; rsh_q <= rsh_d; amt_q <= amt_d;
    end
    if (en_h) begin
      sh_q <= sg_q; mxn_q <= mxn_d; myn_q <= myn_d;
    end
    if (en_i) begin
      si_q <= sh_q; sqx_q <= sqx_d; sqy_q <= sqy_d; mxi_q <= mxn_q; myi_q <= myn_q;
    end
    if (en_j) begin
      sqs_q <= {1'b0, sqx_q} + {1'b0, sqy_q};
      nj_q <= '{side: si_q, mx: mxi_q, my: myi_q};
    end
  end

  obbc_isqrt u_isqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (vj_q),
    .in_stall_o  (sq_stall),
    .in_sq_i     (sqs_q),
    .in_norm_i   (nj_q),
    .out_valid_o (sq_valid),
    .out_stall_i (dv_stall_in),
    .out_root_o  (sq_root),
    .out_norm_o  (sq_norm)
  );

  obbc_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sq_valid),
    .in_stall_o  (dv_stall_in),
    .in_norm_i   (sq_norm),
    .in_len_i    (sq_root),
    .out_valid_o (dv_valid),
    .out_stall_i (dv_stall),
    .out_ax_o    (dv_ax),
    .out_ay_o    (dv_ay),
    .out_side_o  (dv_side)
  );

  // back stages: corner penetration, selection, push and touch
  always_comb begin
    axs     = dv_side.sx ? 18'd0 - {1'b0, dv_ax} : {1'b0, dv_ax};
    ays     = dv_side.sy ? 18'd0 - {1'b0, dv_ay} : {1'b0, dv_ay};
    sk_d    = dv_side;
    sk_d.ax = dv_side.ez ? 18'sd0 : axs;
    sk_d.ay = dv_side.ez ? 18'sd0 : ays;
  end

  assign pdx_d = $signed(sk_q.dx) * sk_q.ax;
  assign pdy_d = $signed(sk_q.dy) * sk_q.ay;
  assign qux_d = sk_q.nx0 * sk_q.ax;
  assign quy_d = sk_q.ny0 * sk_q.ay;
  assign qvx_d = sk_q.nx1 * sk_q.ax;
  assign qvy_d = sk_q.ny1 * sk_q.ay;

  always_comb begin
    das  = {pdx_q[50], pdx_q} + {pdy_q[50], pdy_q};
    dafl = das[51:16];
    da_d = dafl[35] ? 36'd0 - dafl : dafl;
    qs0  = {qux_q[34], qux_q} + {quy_q[34], quy_q};
    qs1  = {qvx_q[34], qvx_q} + {qvy_q[34], qvy_q};
    qa0  = qs0[35] ? 36'd0 - qs0 : qs0;
    qa1  = qs1[35] ? 36'd0 - qs1 : qs1;
    q0_d = qa0[35:14];
    q1_d = qa1[35:14];
  end

  assign w0_d = q0_q * sm_q.hw0;
  assign w1_d = q1_q * sm_q.hw1;

  always_comb begin
    ws     = {1'b0, w0_q} + {1'b0, w1_q};
    penc_d = {2'b0, ws[53:16]} + {9'b0, sn_q.r} - {4'b0, dan_q};
  end

  always_comb begin
    sp_d        = so_q;
    sp_d.corner = penc_q < {{2{so_q.pen_b[37]}}, so_q.pen_b};
    sp_d.miss   = so_q.miss | penc_q[39];
    nbx_d       = so_q.best ? so_q.nx1 : so_q.nx0;
    nby_d       = so_q.best ? so_q.ny1 : so_q.ny0;
    mpen_d      = sp_d.corner ? penc_q : {{2{so_q.pen_b[37]}}, so_q.pen_b};
    max_d       = sp_d.corner ? so_q.ax : {nbx_d[16], nbx_d};
    may_d       = sp_d.corner ? so_q.ay : {nby_d[16], nby_d};
  end

  assign prx_d = mpen_q * max_q;
  assign pry_d = mpen_q * may_q;
  assign rnx_d = $signed({1'b0, sp_q.r}) * nbx_q;
  assign rny_d = $signed({1'b0, sp_q.r}) * nby_q;

  always_comb begin
    negx  = 59'd0 - {prx_q[57], prx_q};
    negy  = 59'd0 - {pry_q[57], pry_q};
    rsx   = rnx_q[48:14];
    rsy   = rny_q[48:14];
    if (sq_q.corner) begin
      pxw_d   = {{2{negx[58]}}, negx[58:16]};
      pyw_d   = {{2{negy[58]}}, negy[58:16]};
      basex_d = {{6{sq_q.bx[31]}}, sq_q.bx} + {{2{sq_q.kx[35]}}, sq_q.kx};
      basey_d = {{6{sq_q.by[31]}}, sq_q.by} + {{2{sq_q.ky[35]}}, sq_q.ky};
    end else begin
      pxw_d   = negx[58:14];
      pyw_d   = negy[58:14];
      basex_d = {{6{sq_q.cx[31]}}, sq_q.cx} - {{3{rsx[34]}}, rsx};
      basey_d = {{6{sq_q.cy[31]}}, sq_q.cy} - {{3{rsy[34]}}, rsy};
    end
  end

  always_comb begin
    hx   = {pxw_q[44], pxw_q[44:1]};
    hy   = {pyw_q[44], pyw_q[44:1]};
    tx48 = sr_q.corner ? {{10{basex_q[37]}}, basex_q} + {{3{hx[44]}}, hx}
                       : {{10{basex_q[37]}}, basex_q} - {{3{hx[44]}}, hx};
    ty48 = sr_q.corner ? {{10{basey_q[37]}}, basey_q} + {{3{hy[44]}}, hy}
                       : {{10{basey_q[37]}}, basey_q} - {{3{hy[44]}}, hy};
    px48 = sr_q.op ? 48'd0 - {{3{pxw_q[44]}}, pxw_q} : {{3{pxw_q[44]}}, pxw_q};
    py48 = sr_q.op ? 48'd0 - {{3{pyw_q[44]}}, pyw_q} : {{3{pyw_q[44]}}, pyw_q};
    if (sr_q.miss) begin
      out_d = '0;
    end else begin
      out_d.colliding = 1'b1;
      out_d.push_x    = obbc_sat(px48);
      out_d.push_y    = obbc_sat(py48);
      out_d.touch_x   = obbc_sat(tx48);
      out_d.touch_y   = obbc_sat(ty48);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_k) sk_q <= sk_d;
    if (en_l) begin
      sl_q <= sk_q; pdx_q <= pdx_d; pdy_q <= pdy_d;
      qux_q <= qux_d; quy_q <= quy_d; qvx_q <= qvx_d; qvy_q <= qvy_d;
    end
    if (en_m) begin
      sm_q <= sl_q; da_q <= da_d; q0_q <= q0_d; q1_q <= q1_d;
    end
    if (en_n) begin
      sn_q <= sm_q; w0_q <= w0_d; w1_q <= w1_d; dan_q <= da_q;
    end
    if (en_o) begin
      so_q <= sn_q; penc_q <= penc_d;
    end
    if (en_p) begin
      sp_q <= sp_d; mpen_q <= mpen_d; max_q <= max_d; may_q <= may_d;
      nbx_q <= nbx_d; nby_q <= nby_d;
    end
    if (en_q) begin
      sq_q <= sp_q; prx_q <= prx_d; pry_q <= pry_d; rnx_q <= rnx_d; rny_q <= rny_d;
    end
    if (en_r) begin
      sr_q <= sq_q; pxw_q <= pxw_d; pyw_q <= pyw_d; basex_q <= basex_d; basey_q <= basey_d;
    end
    if (en_s) out_q <= out_d;
  end

  assign out_valid_o = vs_q;
  assign out_data_o  = out_q;

endmodule

// File: sim/obbc_contact_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// Contact result checker
// Watches both channels of the box/circle contact core, predicts the result
// of every accepted pair and compares each result beat, field by field,
// with the oldest prediction in order.
// ============================================================================
module obbc_contact_checker import obbc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  obbc_in_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  obbc_out_t out_data_i,
  output int        fail_count_o,
  output int        pending_o
);

  obbc_out_t contact_q[$];
  int        fail_count = 0;

  assign fail_count_o = fail_count;
  assign pending_o    = contact_q.size();

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned rt;
    longint unsigned bt;
    rt = 0;
    bt = 64'd1 << 62;
    while (bt > v) bt = bt >> 2;
    while (bt != 0) begin
      if (v >= rt + bt) begin
        v  = v - (rt + bt);
        rt = (rt >> 1) + bt;
      end else begin
        rt = rt >> 1;
      end
      bt = bt >> 2;
    end
    return rt;
  endfunction

  function automatic longint unsigned magnitude(longint v);
    return (v < 0) ? longint'(-v) : v;
  endfunction

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7fff_ffff;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic obbc_out_t predict_contact(obbc_in_t b);
    longint bx, by, cx, cy, dx, dy, r, kx, ky, ex, ey, ax, ay, da, penc;
    longint px, py, tx, ty;
    longint hw[2], nx[2], ny[2], proj[2], pen[2];
    longint unsigned q[2], w, mx, my, mm, len;
    int best;
    obbc_out_t res;
    res = '0;
    bx = b.box_center_x;
    by = b.box_center_y;
    cx = b.ball_center_x;
    cy = b.ball_center_y;
    hw[0] = longint'({33'd0, b.box_half_width});
    hw[1] = longint'({33'd0, b.box_half_height});
    r = longint'({33'd0, b.ball_radius});
    dx = cx - bx;
    dy = cy - by;
    nx[0] = b.box_cos;
    ny[0] = b.box_sin;
    nx[1] = -longint'(b.box_sin);
    ny[1] = b.box_cos;
    for (int i = 0; i < 2; i++) begin
      proj[i] = (dx * nx[i] + dy * ny[i]) >>> 14;
      if (proj[i] < 0) begin
        proj[i] = -proj[i];
        nx[i] = -nx[i];
        ny[i] = -ny[i];
      end
      pen[i] = hw[i] + r - proj[i];
      if (pen[i] < 0) return res;
    end
    best = (pen[1] < pen[0]) ? 1 : 0;
    kx = (nx[0] * hw[0] + nx[1] * hw[1]) >>> 14;
    ky = (ny[0] * hw[0] + ny[1] * hw[1]) >>> 14;
    ex = dx - kx;
    ey = dy - ky;
    ax = 0;
    ay = 0;
    if (ex != 0 || ey != 0) begin
      mx = magnitude(ex);
      my = magnitude(ey);
      mm = (mx > my) ? mx : my;
      while (mm >= (64'd1 << 31)) begin
        mx = mx >> 1; my = my >> 1; mm = mm >> 1;
      end
      while (mm < (64'd1 << 30)) begin
        mx = mx << 1; my = my << 1; mm = mm << 1;
      end
      len = root_floor(mx * mx + my * my);
      ax = longint'((mx << 16) / len);
      ay = longint'((my << 16) / len);
      if (ex < 0) ax = -ax;
      if (ey < 0) ay = -ay;
    end
    da = (dx * ax + dy * ay) >>> 16;
    if (da < 0) da = -da;
    for (int i = 0; i < 2; i++) q[i] = magnitude(nx[i] * ax + ny[i] * ay) >> 14;
    w = (q[0] * hw[0] + q[1] * hw[1]) >> 16;
    penc = longint'(w) + r - da;
    if (penc < 0) return res;
    if (penc < pen[best]) begin
      px = (-penc * ax) >>> 16;
      py = (-penc * ay) >>> 16;
      tx = bx + kx + (px >>> 1);
      ty = by + ky + (py >>> 1);
    end else begin
      px = (-pen[best] * nx[best]) >>> 14;
      py = (-pen[best] * ny[best]) >>> 14;
      tx = cx - ((r * nx[best]) >>> 14) - (px >>> 1);
      ty = cy - ((r * ny[best]) >>> 14) - (py >>> 1);
    end
    if (b.operation) begin
      px = -px;
      py = -py;
    end
    res.colliding = 1'b1;
    res.push_x  = clamp32(px);
    res.push_y  = clamp32(py);
    res.touch_x = clamp32(tx);
    res.touch_y = clamp32(ty);
    return res;
  endfunction

  always @(posedge clk_i) begin
    obbc_out_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) contact_q.push_back(predict_contact(in_data_i));
      if (out_valid_i && !out_stall_i) begin
        if (contact_q.size() == 0) begin
          $error("result beat with no pair outstanding");
          fail_count++;
        end else begin
          want = contact_q.pop_front();
          if (out_data_i.colliding !== want.colliding) begin
            $error("colliding: expected %0d, got %0d", want.colliding, out_data_i.colliding);
            fail_count++;
          end
          if (out_data_i.push_x !== want.push_x) begin
            $error("push_x: expected %0d, got %0d", want.push_x, out_data_i.push_x);
            fail_count++;
          end
          if (out_data_i.push_y !== want.push_y) begin
            $error("push_y: expected %0d, got %0d", want.push_y, out_data_i.push_y);
            fail_count++;
          end
          if (out_data_i.touch_x !== want.touch_x) begin
            $error("touch_x: expected %0d, got %0d", want.touch_x, out_data_i.touch_x);
            fail_count++;
          end
          if (out_data_i.touch_y !== want.touch_y) begin
            $error("touch_y: expected %0d, got %0d", want.touch_y, out_data_i.touch_y);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

// File: sim/oriented_box_circle_contact_core_test.sv
`timescale 1ns / 1ps
// ============================================================================
// Oriented box / circle contact core regression
// Drives directed corner cases and about a thousand random box/circle pairs,
// mostly near contact, with random gaps and output stalls; a checker module
// predicts and compares every result beat.
// ============================================================================
module oriented_box_circle_contact_core_test;
  import obbc_pkg::*;

  localparam int Q = 65536;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  obbc_in_t  in_data;
  logic      out_valid;
  logic      out_stall;
  obbc_out_t out_data;
  int        fail_count;
  int        pending;
  int        gap_max;
  int        hold_left;

  oriented_box_circle_contact_core u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  obbc_contact_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("oriented_box_circle_contact_core regression: fail");
    $finish;
  end

  initial hold_left = 0;

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) hold_left <= $urandom_range(0, gap_max);
  end

  // hold valid high between back-to-back beats; drop it only for a gap
  task automatic send_pair(input obbc_in_t item);
    int gap;
    logic taken;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    taken = 1'b0;
    while (!taken) begin
      #1;
      taken = !in_stall;
      @(negedge clk);
    end
  endtask

  function automatic obbc_in_t make_pair(int op, int bx, int by, int cs, int sn,
                                         int hw, int hh, int cx, int cy, int rad);
    obbc_in_t p;
    p.operation       = op[0];
    p.box_center_x    = bx;
    p.box_center_y    = by;
    p.box_cos         = 16'(cs);
    p.box_sin         = 16'(sn);
    p.box_half_width  = 31'(hw);
    p.box_half_height = 31'(hh);
    p.ball_center_x   = cx;
    p.ball_center_y   = cy;
    p.ball_radius     = 31'(rad);
    return p;
  endfunction

  function automatic obbc_in_t near_pair();
    obbc_in_t p;
    int span, cs, sn, hw, hh, rad, reach;
    span = 1 << $urandom_range(12, 22);
    hw  = $urandom_range(0, span);
    hh  = $urandom_range(0, span);
    rad = $urandom_range(0, span);
    cs  = int'($urandom_range(0, 32768)) - 16384;
    if ($urandom_range(0, 4) == 0) begin
      sn = int'($urandom_range(0, 32768)) - 16384;
    end else begin
      sn = int'($sqrt(real'(16384 * 16384 - cs * cs)));
      if ($urandom_range(0, 1)) sn = -sn;
    end
    reach = hw + hh + rad + 2;
    p = make_pair($urandom_range(0, 1), $urandom, $urandom, cs, sn, hw, hh, 0, 0, rad);
    p.box_center_x  = $signed(p.box_center_x) >>> $urandom_range(0, 8);
    p.box_center_y  = $signed(p.box_center_y) >>> $urandom_range(0, 8);
    p.ball_center_x = p.box_center_x + int'($urandom_range(0, 2 * reach)) - reach;
    p.ball_center_y = p.box_center_y + int'($urandom_range(0, 2 * reach)) - reach;
    return p;
  endfunction

  initial begin
    obbc_in_t item;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    gap_max   = 6;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_pair(make_pair(0, 0, 0, 16384, 0, Q, Q, Q / 2, Q / 4, Q));
    send_pair(make_pair(1, 0, 0, 16384, 0, Q, Q, Q / 2, Q / 4, Q));
    send_pair(make_pair(0, 0, 0, 16384, 0, Q, Q, 10 * Q, 0, Q));
    send_pair(make_pair(0, 0, 0, 16384, 0, Q, Q, 3 * Q, 3 * Q, Q));
    send_pair(make_pair(0, 0, 0, 16384, 0, Q, Q, Q, Q, Q));
    send_pair(make_pair(1, 0, 0, 16384, 0, Q, Q, Q, Q, 0));
    send_pair(make_pair(0, 0, 0, 16384, 0, Q, Q, 0, 0, Q));
    send_pair(make_pair(0, 0, 0, 16384, 0, Q, Q, 2 * Q, 0, Q));
    send_pair(make_pair(0, 0, 0, 16384, 0, Q, Q, Q + Q / 2, Q + Q / 2, Q));
    send_pair(make_pair(1, Q, -Q, 11585, 11585, 2 * Q, Q, 3 * Q, Q, Q / 2));
    send_pair(make_pair(0, 0, 0, -16384, -16384, Q, 2 * Q, Q, -Q, Q));
    send_pair(make_pair(0, 0, 0, 16384, 16384, Q, Q, 0, 2 * Q, Q));
    send_pair(make_pair(0, 0, 0, 0, 0, Q, Q, 5 * Q, 5 * Q, Q));
    send_pair(make_pair(0, 32'h7fff_0000, 32'h7fff_0000, 16384, 0, 32'h7fff_ffff,
                        32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
    send_pair(make_pair(1, 32'h8000_0000, 32'h8000_0000, -16384, 0, 32'h7fff_ffff,
                        32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff));
    send_pair(make_pair(0, 32'h8000_0000, 32'h7fff_ffff, 0, 16384, 0, 0,
                        32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff));
    send_pair(make_pair(1, 32'h7fff_ffff, 32'h8000_0000, 0, -16384, 32'h7fff_ffff, 0,
                        32'h8000_0000, 32'h7fff_ffff, 0));
    send_pair(make_pair(0, 0, 0, 16384, 0, 0, 0, 0, 0, 0));
    send_pair(make_pair(1, -Q, -Q, 0, 16384, 32'h7fff_ffff, 32'h7fff_ffff, Q, Q, 0));

    for (int n = 0; n < 1050; n++) begin
      if (n % 150 == 0) gap_max = (n % 300 == 0) ? 0 : 6;
      if ($urandom_range(0, 9) < 8) begin
        item = near_pair();
      end else begin
        item = make_pair($urandom_range(0, 1), $urandom, $urandom,
                         int'($urandom_range(0, 32768)) - 16384,
                         int'($urandom_range(0, 32768)) - 16384,
                         $urandom, $urandom, $urandom, $urandom, $urandom);
      end
      send_pair(item);
    end
    in_valid <= 1'b0;

    gap_max = 6;
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (fail_count == 0) begin
      $display("oriented_box_circle_contact_core regression: pass");
    end else begin
      $display("oriented_box_circle_contact_core regression: fail");
    end
    $finish;
  end

endmodule
